// ===== hw/rtl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page frame replacement unit.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Address split: fixed page size, so page and offset are plain bit fields
  localparam int PAGE_SIZE   = 256;
  localparam int OFF_W       = $clog2(PAGE_SIZE);
  localparam int PAGE_W      = 8;
  localparam int ADDR_W      = OFF_W + PAGE_W;
  localparam int TIME_W      = 16;
  localparam int STAMP_W     = TIME_W + 1;
  localparam int LIMIT_W     = 9;
  localparam int FIDX_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int WORD_W      = PAGE_W + STAMP_W;

  localparam int FRAMES_DEF  = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_W   = ADDR_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = STATUS_W + FIDX_W + PAGE_W + OFF_W + PAGE_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT   = 2'd0,
    ST_FILL  = 2'd1,
    ST_EVICT = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture a new item
    logic scan;    // evaluate the frame at the scan index
    logic first;   // scan index is frame 0
    logic commit;  // update frame state and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new item this cycle
  } sts_t;

endpackage

// ===== hw/rtl/lru_page_frame_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_replacement_unit
// Fully associative LRU page frame replacement over FRAMES frames.
// ----------------------------------------------------------------------------
// Each input item carries a 16-bit logical address and a 16-bit access time
// stamp. The address splits into page (upper 8 bits) and offset (lower 8
// bits, 256-byte pages). A page at or above page_limit is reported out of
// range and leaves the frames untouched. A page held in a valid frame is a
// hit and refreshes that frame's stamp; otherwise the frame with the smallest
// stamp (lowest index on ties, empty frames first) takes the page. One result
// item comes back per input item. The frames sit in a small memory with one
// registered read port, so the block scans one frame per cycle and then
// commits; the commit waits while the result register holds a result that
// has not been taken. The next item is taken in the commit cycle, so the
// block takes no new item before it has committed the last. The result
// register decouples the output: a waiting result does not block the next
// scan, only the next commit. No clearing pass is needed after reset;
// page_limit resets to 10 and may be written while the block is idle.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement_unit #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [15:0] logical_address, [31:16] access_time
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [1:0] status, [3:2] frame_index, [11:4] page_number,
  //            [19:12] page_offset, [27:20] evicted_page, [31:28] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // page_limit write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrupr_pkg::LIMIT_W-1:0]     cfg_data
);
  import lrupr_pkg::*;

  localparam int CNT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] rd_addr;

  // the user must write config only while idle; the block does not enforce it, so always take it
  assign cfg_ready = 1'b1;

  lrupr_ctrl #(
    .FRAMES (FRAMES),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .rd_addr   (rd_addr)
  );

  lrupr_dp #(
    .FRAMES (FRAMES),
    .CNT_W  (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_addr    (in_tdata[ADDR_W-1:0]),
    .in_time    (in_tdata[ADDR_W +: TIME_W]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_limit  (cfg_data),
    .cmd        (cmd),
    .scan_idx   (scan_idx),
    .rd_addr    (rd_addr),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/lrupr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: accept, scan the frames one per cycle, commit the result.
// ----------------------------------------------------------------------------
module lrupr_ctrl #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF,
  parameter int CNT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lrupr_pkg::sts_t    sts,
  output lrupr_pkg::cmd_t    cmd,
  output logic [CNT_W-1:0]   scan_idx,
  output logic [CNT_W-1:0]   rd_addr
);
  import lrupr_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAMES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             commit;

  assign commit    = (state_r == S_WRITE) && sts.out_free;
  assign in_tready = (state_r == S_IDLE) || commit;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST) begin
          state_nxt = S_WRITE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_WRITE: begin
        if (commit) begin
          // take the next item in the commit cycle
          state_nxt = accept ? S_SCAN : S_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cmd.load   = accept;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.first  = (cnt_r == '0);
  assign cmd.commit = commit;
  assign scan_idx   = cnt_r;
  // prefetch the next frame; frame 0 is read during the accept cycle
  assign rd_addr    = ((state_r == S_SCAN) && (cnt_r != LAST)) ? cnt_r + CNT_W'(1) : '0;

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_tready)
    else $error("input accepted during frame scan");

  a_scan_reaches_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (cnt_r == LAST) |=> (state_r == S_WRITE))
    else $error("scan did not end in commit state");

endmodule

// ===== hw/rtl/lrupr_dp.sv =====
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame store, hit search, minimum-stamp victim search and result register.
// ----------------------------------------------------------------------------
module lrupr_dp #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF,
  parameter int CNT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lrupr_pkg::ADDR_W-1:0]      in_addr,
  input  logic [lrupr_pkg::TIME_W-1:0]      in_time,
  input  logic                              cfg_we,
  input  logic [lrupr_pkg::LIMIT_W-1:0]     cfg_limit,
  input  lrupr_pkg::cmd_t                   cmd,
  input  logic [CNT_W-1:0]                  scan_idx,
  input  logic [CNT_W-1:0]                  rd_addr,
  output lrupr_pkg::sts_t                   sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lrupr_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [TIME_W-1:0]  time_r;

  // frame store: page and stamp per frame, validity in flip-flops
  logic [WORD_W-1:0]  frame_mem_r [FRAMES];
  logic [WORD_W-1:0]  mem_q_r;
  logic               byp_r;
  logic [WORD_W-1:0]  byp_word_r;
  logic [FRAMES-1:0]  valid_r;

  // scan results
  logic               hit_r;
  logic [CNT_W-1:0]   hit_idx_r;
  logic [CNT_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic               best_valid_r;
  logic [PAGE_W-1:0]  best_page_r;

  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic [PAGE_W-1:0]  page;
  logic [OFF_W-1:0]   offset;
  logic               oor;
  logic [WORD_W-1:0]  e_word;
  logic               e_valid;
  logic [PAGE_W-1:0]  e_page;
  logic [STAMP_W-1:0] e_stamp;
  logic               e_match;
  logic               e_less;
  logic [CNT_W-1:0]   tgt;
  logic [CNT_W+1:0]   tgt_ext;
  logic               wr_en;
  logic [WORD_W-1:0]  wr_word;
  status_t            status;
  logic [FIDX_W-1:0]  frame_out;
  logic [PAGE_W-1:0]  evicted;

  assign page   = addr_r[OFF_W +: PAGE_W];
  assign offset = addr_r[OFF_W-1:0];
  assign oor    = {1'b0, page} >= limit_r;

  // entry under scan; an empty frame reads as page 0, stamp -1
  always_comb begin
    e_word  = byp_r ? byp_word_r : mem_q_r;
    e_valid = valid_r[scan_idx];
    e_page  = e_valid ? e_word[WORD_W-1 -: PAGE_W] : '0;
    e_stamp = e_valid ? e_word[STAMP_W-1:0] : '1;
    e_match = e_valid && (e_page == page);
    e_less  = $signed(e_stamp) < $signed(best_stamp_r);
  end

  // commit
  always_comb begin
    tgt     = hit_r ? hit_idx_r : best_idx_r;
    tgt_ext = {2'b00, tgt};
    wr_en   = cmd.commit && !oor;
    wr_word = {page, 1'b0, time_r};
    if (oor) begin
      status = ST_RANGE;
    end else if (hit_r) begin
      status = ST_HIT;
    end else if (best_valid_r) begin
      status = ST_EVICT;
    end else begin
      status = ST_FILL;
    end
    frame_out = oor ? '0 : tgt_ext[FIDX_W-1:0];
    evicted   = (status == ST_EVICT) ? best_page_r : '0;
  end

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_addr;
      time_r <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem_r[tgt] <= wr_word;
    end
    mem_q_r    <= frame_mem_r[rd_addr];
    // forward a write that lands on the frame being read
    byp_r      <= wr_en && (tgt == rd_addr);
    byp_word_r <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (cmd.first) begin
        hit_r     <= e_match;
        hit_idx_r <= scan_idx;
      end else if (!hit_r && e_match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= scan_idx;
      end
      if (cmd.first || e_less) begin
        best_idx_r   <= scan_idx;
        best_stamp_r <= e_stamp;
        best_valid_r <= e_valid;
        best_page_r  <= e_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {evicted, offset, page, frame_out, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_DATA_W){1'b0}}, out_data_r};

  a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not load the result register");

  a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r[STATUS_W-1:0] == ST_RANGE) |->
      (out_data_r[STATUS_W +: FIDX_W] == '0) && (out_data_r[OUT_DATA_W-1 -: PAGE_W] == '0))
    else $error("out of range result carries a frame or evicted page");

  a_valid_sticky: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> ((valid_r & $past(valid_r)) == $past(valid_r)))
    else $error("frame lost its valid bit");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU page frame replacement unit.
// ----------------------------------------------------------------------------
// Drives address/time-stamp items into the slave stream. A behavioral LRU
// model in this file predicts every result item, and the master stream is
// checked field by field against it, or against a result typed in by hand.
// A short table of directed rows, many typed in, comes first. Random phases
// under several page limits follow. The sender idles in bursts, the receiver
// stalls on its own pattern, and a long receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
module tb_top;
  import lrupr_pkg::*;

  localparam int FRAMES      = FRAMES_DEF;
  localparam int HOLD_CYCLES = 150;  // long receiver hold-off
  localparam int SETTLE      = 8;    // idle cycles before a limit write

  // One result item, unpacked by hand from out_tdata
  typedef struct packed {
    status_t            status;
    logic [FIDX_W-1:0]  frame;
    logic [PAGE_W-1:0]  page;
    logic [OFF_W-1:0]   offset;
    logic [PAGE_W-1:0]  evicted;
  } acc_res_t;

  typedef enum logic {ROW_ACCESS, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [LIMIT_W-1:0] limit;
    logic [15:0]        addr;
    logic [15:0]        stamp;
    logic               known;  // result typed in below, else predicted
    acc_res_t           want;
  } row_t;

  localparam acc_res_t NO_RES = '{ST_HIT, 2'd0, 8'h00, 8'h00, 8'h00};

  // Directed rows. Reset limit is 10, so the first rows fill the three
  // empty frames in index order, then walk hits, evictions, out of range
  // pages, a falling stamp and limits of zero, one and above 255.
  localparam int NROWS = 23;
  localparam row_t PLAN [NROWS] = '{
    '{ROW_ACCESS, 9'd0,   16'h0000, 16'h0000, 1'b1, '{ST_FILL,  2'd0, 8'h00, 8'h00, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h01FF, 16'h0001, 1'b1, '{ST_FILL,  2'd1, 8'h01, 8'hFF, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h0280, 16'h0002, 1'b1, '{ST_FILL,  2'd2, 8'h02, 8'h80, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h0005, 16'h0003, 1'b1, '{ST_HIT,   2'd0, 8'h00, 8'h05, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h0300, 16'h0004, 1'b1, '{ST_EVICT, 2'd1, 8'h03, 8'h00, 8'h01}},
    '{ROW_ACCESS, 9'd0,   16'h0A00, 16'h0005, 1'b1, '{ST_RANGE, 2'd0, 8'h0A, 8'h00, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'hFFFF, 16'hFFFF, 1'b1, '{ST_RANGE, 2'd0, 8'hFF, 8'hFF, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h0900, 16'h0006, 1'b1, '{ST_EVICT, 2'd2, 8'h09, 8'h00, 8'h02}},
    // falling stamp: stored as given
    '{ROW_ACCESS, 9'd0,   16'h0400, 16'h0000, 1'b1, '{ST_EVICT, 2'd0, 8'h04, 8'h00, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h0700, 16'h0007, 1'b1, '{ST_EVICT, 2'd0, 8'h07, 8'h00, 8'h04}},
    // limit of zero: everything out of range
    '{ROW_LIMIT,  9'd0,   16'h0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_ACCESS, 9'd0,   16'h0000, 16'h0008, 1'b1, '{ST_RANGE, 2'd0, 8'h00, 8'h00, 8'h00}},
    '{ROW_LIMIT,  9'h1FF, 16'h0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_ACCESS, 9'd0,   16'hFF12, 16'hFFFF, 1'b1, '{ST_EVICT, 2'd1, 8'hFF, 8'h12, 8'h03}},
    '{ROW_ACCESS, 9'd0,   16'h8034, 16'h8000, 1'b1, '{ST_EVICT, 2'd2, 8'h80, 8'h34, 8'h09}},
    '{ROW_LIMIT,  9'd1,   16'h0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_ACCESS, 9'd0,   16'h00AA, 16'h8001, 1'b1, '{ST_EVICT, 2'd0, 8'h00, 8'hAA, 8'h07}},
    '{ROW_ACCESS, 9'd0,   16'h0100, 16'h8002, 1'b1, '{ST_RANGE, 2'd0, 8'h01, 8'h00, 8'h00}},
    '{ROW_LIMIT,  9'd256, 16'h0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_ACCESS, 9'd0,   16'hFF00, 16'h8003, 1'b1, '{ST_HIT,   2'd1, 8'hFF, 8'h00, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h8000, 16'h8003, 1'b1, '{ST_HIT,   2'd2, 8'h80, 8'h00, 8'h00}},
    '{ROW_ACCESS, 9'd0,   16'h5555, 16'h2AAA, 1'b0, NO_RES},
    '{ROW_ACCESS, 9'd0,   16'hAAAA, 16'h5555, 1'b0, NO_RES}
  };

  // Random phases: page limit per phase (a negative entry draws one)
  localparam int NPHASES = 8;
  localparam int PHASE_LIMIT [NPHASES] = '{10, 4, 256, 1, 511, 0, -1, 3};
  localparam int PHASE_ITEMS [NPHASES] = '{220, 220, 220, 200, 220, 60, 220, 200};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [LIMIT_W-1:0]     cfg_data   = '0;

  // Model state of the frames and the limit register
  logic [PAGE_W-1:0]         fr_page  [FRAMES];
  logic                      fr_valid [FRAMES];
  logic signed [STAMP_W-1:0] fr_stamp [FRAMES];
  logic [LIMIT_W-1:0]        limit_reg;

  acc_res_t pending_results [$];
  acc_res_t got_res, want_res;
  int       mismatches = 0;
  int       burst_left = 0;
  bit       hold_req   = 1'b0;

  lru_page_frame_replacement_unit #(.FRAMES(FRAMES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] logical_address, [31:16] access_time
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [1:0] status, [3:2] frame, [11:4] page,
                               // [19:12] offset, [27:20] evicted page
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // page_limit
  );

  always #5 clk = ~clk;

  // Look up one access in the model frames and update them. Out of range
  // pages leave the frames alone; a miss takes the smallest stamp, lowest
  // index on ties, and empty frames (stamp -1) go first.
  function automatic acc_res_t lru_lookup(logic [15:0] addr, logic [15:0] stamp);
    acc_res_t                  r;
    logic [PAGE_W-1:0]         pg;
    logic signed [STAMP_W-1:0] now;
    logic signed [STAMP_W-1:0] best;
    int                        hit_idx;
    int                        victim;
    pg      = addr[15:8];
    now     = {1'b0, stamp};
    r       = '{ST_HIT, 2'd0, pg, addr[7:0], 8'h00};
    hit_idx = -1;
    if ({1'b0, pg} >= limit_reg) begin
      r.status = ST_RANGE;
    end else begin
      for (int i = 0; i < FRAMES; i++)
        if (hit_idx < 0 && fr_valid[i] && fr_page[i] == pg) hit_idx = i;
      if (hit_idx >= 0) begin
        r.frame           = FIDX_W'(hit_idx);
        fr_stamp[hit_idx] = now;
      end else begin
        victim = 0;
        best   = fr_stamp[0];
        for (int i = 1; i < FRAMES; i++) begin
          if (fr_stamp[i] < best) begin
            victim = i;
            best   = fr_stamp[i];
          end
        end
        r.frame = FIDX_W'(victim);
        if (fr_valid[victim]) begin
          r.status  = ST_EVICT;
          r.evicted = fr_page[victim];
        end else begin
          r.status = ST_FILL;
        end
        fr_page[victim]  = pg;
        fr_valid[victim] = 1'b1;
        fr_stamp[victim] = now;
      end
    end
    return r;
  endfunction

  // Offer one item at the falling edge and hold it until accepted, then
  // queue its expected result (typed in or predicted).
  task automatic drive_access(input logic [15:0] addr, input logic [15:0] stamp,
                              input logic known, input acc_res_t want);
    acc_res_t pred;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, addr};
    do @(posedge clk); while (!in_tready);
    pred = lru_lookup(addr, stamp);
    pending_results.push_back(known ? want : pred);
  endtask

  // Sender pacing: keep valid up through a burst, then drop it for a gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Write page_limit once the unit has drained
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: segments of always-ready, random stalls or a periodic
  // stall; a hold request parks tready low for a long counted stretch.
  initial begin
    int seg, kind, per;
    forever begin
      seg  = $urandom_range(20, 200);
      kind = $urandom_range(0, 2);
      per  = $urandom_range(2, 5);
      for (int n = 0; n < seg; n++) begin
        @(negedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (kind)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 2) != 0);
            default: out_tready <= ((n % per) != 0);
          endcase
        end
      end
    end
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.status  = status_t'(out_tdata[1:0]);
      got_res.frame   = out_tdata[3:2];
      got_res.page    = out_tdata[11:4];
      got_res.offset  = out_tdata[19:12];
      got_res.evicted = out_tdata[27:20];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d fr=%0d pg=%02h off=%02h ev=%02h",
                   got_res.status, got_res.frame, got_res.page, got_res.offset,
                   got_res.evicted);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d fr=%0d pg=%02h off=%02h ev=%02h, ",
                      "got st=%0d fr=%0d pg=%02h off=%02h ev=%02h"},
                     want_res.status, want_res.frame, want_res.page,
                     want_res.offset, want_res.evicted, got_res.status,
                     got_res.frame, got_res.page, got_res.offset,
                     got_res.evicted);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int                 lim_pages, pool, base, sel, drain;
    logic [PAGE_W-1:0]  pg;
    logic [15:0]        now;
    logic [LIMIT_W-1:0] lim;

    // reset state of the model
    limit_reg = LIMIT_RESET;
    for (int i = 0; i < FRAMES; i++) begin
      fr_page[i]  = '0;
      fr_valid[i] = 1'b0;
      fr_stamp[i] = '1;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < NROWS; r++) begin
      if (PLAN[r].kind == ROW_LIMIT) begin
        write_limit(PLAN[r].limit);
      end else begin
        drive_access(PLAN[r].addr, PLAN[r].stamp, PLAN[r].known, PLAN[r].want);
        pace();
      end
    end

    // random phases
    now = 16'h9000;
    for (int p = 0; p < NPHASES; p++) begin
      lim = (PHASE_LIMIT[p] < 0) ? LIMIT_W'($urandom_range(1, 511))
                                 : LIMIT_W'(PHASE_LIMIT[p]);
      write_limit(lim);
      lim_pages = (lim > 256) ? 256 : int'(lim);
      pool      = (lim_pages < 5) ? lim_pages : 5;
      base      = (lim_pages > 0) ? $urandom_range(0, lim_pages - pool) : 0;

      // long receiver hold-off while the sender keeps offering items
      if (p == 1 || p == 4) begin
        hold_req   = 1'b1;
        burst_left = 60;
      end

      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        // mostly a small working set inside the limit so frames churn;
        // the rest anywhere or right around the limit
        sel = $urandom_range(0, 99);
        if (sel < 75 && lim_pages > 0) begin
          if ($urandom_range(0, 49) == 0) base = $urandom_range(0, lim_pages - pool);
          pg = PAGE_W'(base + $urandom_range(0, pool - 1));
        end else if (sel < 90) begin
          pg = PAGE_W'($urandom_range(0, 255));
        end else begin
          pg = PAGE_W'((lim + $urandom_range(0, 2) > 256) ? 255
                       : ((lim == 0) ? 0 : lim - 1 + $urandom_range(0, 2)));
        end

        // stamps mostly creep up, with ties, jumps and falls now and then
        sel = $urandom_range(0, 99);
        if (sel < 5)       now = 16'($urandom_range(0, 65535));
        else if (sel < 10) now = now + 16'($urandom_range(0, 3000));
        else               now = now + 16'($urandom_range(0, 3));

        drive_access({pg, 8'($urandom_range(0, 255))}, now, 1'b0, NO_RES);
        pace();
      end
    end

    // drain and finish
    @(negedge clk);
    in_tvalid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_results.size() != 0) begin
      if (mismatches < 10)
        $display("missing results: %0d expected items never arrived",
                 pending_results.size());
      mismatches += pending_results.size();
    end
    repeat (4 * (FRAMES + 1)) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
